// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

    // Decoded length kept to this many bits (16..64)
    localparam int LENGTH_BITS = 64;
    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Extended length and mask key byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Output stream widths
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    // Parser phases
    typedef enum logic [4:0] {
        PH_FLAGS   = 5'b00001,
        PH_LEN7    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // One classified item from the parser, still masked
    typedef struct packed {
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic [7:0]  flags;
        logic [63:0] length;
        logic        masked;
        logic        empty;
        logic        frame_end;
    } t_item;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
//
//  channel | dir | tdata (low bit up)                      | tlast     | tuser (low bit up)
//  s_axis  | in  | rx_byte[7:0]                            | -         | -
//  m_axis  | out | payload_byte, frame_flags, frame_length | frame_end | was_masked, empty_frame
//
// One byte is accepted per cycle while the queue has room; a payload byte is written
// into the queue at the edge that accepts it and then into the output register.
// Header bytes produce no output; a zero-length frame produces one item on its
// last header byte. i_rst_n (synchronous) clears the parser phase, the queue and
// the output valid. A 4-item queue absorbs output stalls; s_axis_tready drops
// only once that queue is full.
`timescale 1ns / 1ps
module websocket_frame_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte[7:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // payload_byte[7:0], frame_flags[15:8], frame_length[79:16]
    output logic [wsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // was_masked[0], empty_frame[1]
    output logic [wsd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import wsd_pkg::*;

    logic  accept;
    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    t_item front_item;
    t_item q_item;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_item   (front_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/wsd_front.sv =====
// Header parser: accepts received bytes and classifies them into queue items.
`timescale 1ns / 1ps
module wsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output wsd_pkg::t_item o_item
);
    import wsd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_hidx,   n_hidx;
    logic [7:0]  r_flags,  n_flags;
    logic        r_masked, n_masked;
    logic [31:0] r_key,    n_key;
    logic [63:0] r_size,   n_size;
    logic [63:0] r_remain, n_remain;
    logic [1:0]  r_kidx,   n_kidx;
    logic        r_ext_long, n_ext_long;

    logic        fin_len;
    logic        fin_hdr;
    logic [63:0] sz_new;
    logic [63:0] shifted;
    logic [3:0]  hidx_inc;
    logic        is_end;
    logic [7:0]  key_sel;

    // Key byte for the current payload position, first key byte at index 0
    always_comb begin
        case (r_kidx)
            2'd0:    key_sel = r_key[31:24];
            2'd1:    key_sel = r_key[23:16];
            2'd2:    key_sel = r_key[15:8];
            2'd3:    key_sel = r_key[7:0];
            default: key_sel = 8'd0;
        endcase
    end

    // Next-state and item build
    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_flags    = r_flags;
        n_masked   = r_masked;
        n_key      = r_key;
        n_size     = r_size;
        n_remain   = r_remain;
        n_kidx     = r_kidx;
        n_ext_long = r_ext_long;
        fin_len    = 1'b0;
        fin_hdr    = 1'b0;
        sz_new     = '0;
        shifted    = {r_size[55:0], i_byte};
        hidx_inc   = r_hidx + 4'd1;
        is_end     = (r_remain == 64'd1);
        o_push     = 1'b0;
        o_item     = '0;

        if (i_accept) begin
            case (r_phase)
                PH_FLAGS: begin
                    n_flags  = i_byte;
                    n_masked = 1'b0;
                    n_key    = '0;
                    n_size   = '0;
                    n_hidx   = '0;
                    n_phase  = PH_LEN7;
                end
                PH_LEN7: begin
                    n_masked = i_byte[7];
                    n_hidx   = '0;
                    if (i_byte[6:0] < LEN_CODE_16) begin
                        fin_len = 1'b1;
                        sz_new  = {57'd0, i_byte[6:0]};
                    end else begin
                        n_ext_long = (i_byte[6:0] == LEN_CODE_64);
                        n_size     = '0;
                        n_phase    = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    n_hidx = hidx_inc;
                    if (hidx_inc >= (r_ext_long ? EXT64_BYTES : EXT16_BYTES)) begin
                        fin_len = 1'b1;
                        sz_new  = shifted;
                    end else begin
                        n_size = shifted;
                    end
                end
                PH_MASK: begin
                    n_key  = {r_key[23:0], i_byte};
                    n_hidx = hidx_inc;
                    if (hidx_inc >= KEY_BYTES) begin
                        fin_hdr = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    o_push             = 1'b1;
                    o_item.raw_byte    = i_byte;
                    o_item.key_byte    = r_masked ? key_sel : 8'd0;
                    o_item.flags       = r_flags;
                    o_item.length      = r_size;
                    o_item.masked      = r_masked;
                    o_item.empty       = 1'b0;
                    o_item.frame_end   = is_end;
                    n_remain           = r_remain - 64'd1;
                    n_kidx             = r_kidx + 2'd1;
                    if (is_end) begin
                        n_phase = PH_FLAGS;
                    end
                end
                default: begin
                    n_phase = PH_FLAGS;
                end
            endcase

            // Length known: trim, then go for the key or finish the header
            if (fin_len) begin
                n_size = sz_new & LEN_MASK;
                n_hidx = '0;
                if (n_masked) begin
                    n_phase = PH_MASK;
                end else begin
                    fin_hdr = 1'b1;
                end
            end

            // Header complete: empty frame result or start of payload
            if (fin_hdr) begin
                n_hidx   = '0;
                n_kidx   = '0;
                n_remain = n_size;
                if (n_size == 64'd0) begin
                    o_push           = 1'b1;
                    o_item.raw_byte  = 8'd0;
                    o_item.key_byte  = 8'd0;
                    o_item.flags     = r_flags;
                    o_item.length    = n_size;
                    o_item.masked    = n_masked;
                    o_item.empty     = 1'b1;
                    o_item.frame_end = 1'b1;
                    n_phase          = PH_FLAGS;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAGS;
            r_hidx     <= '0;
            r_kidx     <= '0;
            r_masked   <= 1'b0;
            r_ext_long <= 1'b0;
            r_remain   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_kidx     <= n_kidx;
            r_masked   <= n_masked;
            r_ext_long <= n_ext_long;
            r_remain   <= n_remain;
        end
    end

    // Header payload registers
    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_key   <= n_key;
        r_size  <= n_size;
    end

endmodule

// ===== rtl/wsd_queue.sv =====
// Short item queue between the parser and the output stage.
`timescale 1ns / 1ps
module wsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsd_pkg::t_item i_item,
    input  logic           i_pop,
    output wsd_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);
    import wsd_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/wsd_back.sv =====
// Output stage: unmasks queued items and holds them in the output register.
`timescale 1ns / 1ps
module wsd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wsd_pkg::t_item                  i_item,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic [wsd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import wsd_pkg::*;

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data, n_data;
    logic                   r_last;
    logic [OUT_TUSER_W-1:0] r_user;

    // Load the output register whenever it is free or being taken
    assign o_pop  = !i_q_empty && (!r_valid || m_axis_tready);
    assign n_data = {i_item.length, i_item.flags, i_item.raw_byte ^ i_item.key_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_last <= i_item.frame_end;
            r_user <= {i_item.empty, i_item.masked};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_user;

endmodule

// ===== rtl/wsd_chk.sv =====
// Port-level checker for the WebSocket frame deframer, bound to the top level.
`timescale 1ns / 1ps
module wsd_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic [wsd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import wsd_pkg::*;

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // Reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // An empty-frame item is a frame end with zero byte and zero length
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tlast && (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[79:16] == 64'd0))
        else $error("malformed empty-frame item");

    // A payload item always belongs to a frame of nonzero length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[79:16] != 64'd0))
        else $error("payload item with zero length");

    // Input stalls only behind a held output item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

endmodule

bind websocket_frame_deframer wsd_chk u_wsd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/websocket_frame_checker.sv =====
// Checker for the frame deframer: predicts deframed items and compares the output stream.
`timescale 1ns / 1ps
module websocket_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // rx_byte[7:0]
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // payload_byte[7:0], frame_flags[15:8], frame_length[79:16]
    input  logic [wsd_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                            i_m_axis_tlast,   // frame_end
    // was_masked[0], empty_frame[1]
    input  logic [wsd_pkg::OUT_TUSER_W-1:0] i_m_axis_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    import wsd_pkg::*;

    // One deframed item as the output stream should carry it
    typedef struct packed {
        logic [7:0]  payload;
        logic [7:0]  flags;
        logic [63:0] length;
        logic        masked;
        logic        empty;
        logic        last;
    } t_deframed;

    t_deframed deframed_q[$];

    // Header parser state of the prediction
    t_phase      hdr_phase = PH_FLAGS;
    logic [3:0]  hdr_count = '0;
    logic [3:0]  ext_bytes = '0;
    logic [7:0]  cur_flags = '0;
    logic        cur_masked = 1'b0;
    logic [31:0] cur_key = '0;
    logic [63:0] cur_len = '0;
    logic [63:0] pay_idx = '0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Header done: a zero-length frame yields its single empty item here
    task automatic close_header();
        hdr_count = '0;
        pay_idx   = '0;
        if (cur_len == 64'd0) begin
            deframed_q.push_back(t_deframed'{payload: 8'h00, flags: cur_flags, length: cur_len,
                                             masked: cur_masked, empty: 1'b1, last: 1'b1});
            hdr_phase = PH_FLAGS;
        end else begin
            hdr_phase = PH_PAYLOAD;
        end
    endtask

    // Length done: trim to the kept width, then the key or the end of the header
    task automatic close_length();
        cur_len   = cur_len & LEN_MASK;
        hdr_count = '0;
        if (cur_masked)
            hdr_phase = PH_MASK;
        else
            close_header();
    endtask

    // Advance the parser by one received byte
    task automatic deframe_byte(input logic [7:0] rx);
        logic [7:0] key_byte;
        logic       at_end;
        case (hdr_phase)
            PH_FLAGS: begin
                cur_flags  = rx;
                cur_masked = 1'b0;
                cur_key    = '0;
                cur_len    = '0;
                hdr_count  = '0;
                hdr_phase  = PH_LEN7;
            end
            PH_LEN7: begin
                cur_masked = rx[7];
                hdr_count  = '0;
                if (rx[6:0] < LEN_CODE_16) begin
                    cur_len = 64'(rx[6:0]);
                    close_length();
                end else begin
                    ext_bytes = (rx[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
                    cur_len   = '0;
                    hdr_phase = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                cur_len   = {cur_len[55:0], rx};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= ext_bytes)
                    close_length();
            end
            PH_MASK: begin
                cur_key   = {cur_key[23:0], rx};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= KEY_BYTES)
                    close_header();
            end
            PH_PAYLOAD: begin
                // first key byte goes with payload index 0 mod 4
                key_byte = cur_masked ? cur_key[8*(3-pay_idx[1:0]) +: 8] : 8'h00;
                at_end   = (pay_idx == cur_len - 64'd1);
                deframed_q.push_back(t_deframed'{payload: rx ^ key_byte, flags: cur_flags,
                                                 length: cur_len, masked: cur_masked,
                                                 empty: 1'b0, last: at_end});
                pay_idx = pay_idx + 64'd1;
                if (at_end) begin
                    hdr_phase = PH_FLAGS;
                    pay_idx   = '0;
                end
            end
            default: hdr_phase = PH_FLAGS;
        endcase
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // Inputs are predicted before outputs are checked at the same edge
    always @(posedge i_clk) begin
        t_deframed want;
        if (!i_rst_n) begin
            deframed_q.delete();
            hdr_phase  = PH_FLAGS;
            hdr_count  = '0;
            ext_bytes  = '0;
            cur_flags  = '0;
            cur_masked = 1'b0;
            cur_key    = '0;
            cur_len    = '0;
            pay_idx    = '0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                deframe_byte(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (deframed_q.size() == 0) begin
                    $error("output item with none expected: tdata 0x%0h", i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = deframed_q.pop_front();
                    check_field("payload_byte", 64'(want.payload), 64'(i_m_axis_tdata[7:0]));
                    check_field("frame_flags", 64'(want.flags), 64'(i_m_axis_tdata[15:8]));
                    check_field("frame_length", want.length, i_m_axis_tdata[79:16]);
                    check_field("was_masked", 64'(want.masked), 64'(i_m_axis_tuser[0]));
                    check_field("empty_frame", 64'(want.empty), 64'(i_m_axis_tuser[1]));
                    check_field("frame_end", 64'(want.last), 64'(i_m_axis_tlast));
                end
            end
        end
        o_pending = deframed_q.size();
    end

endmodule

// ===== dv/tb_websocket_frame_deframer.sv =====
// Testbench top for the frame deframer: byte stream stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int STREAM_BYTES = 1500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MSB_PAYLOAD  = 24;

    // Length encodings of the second header byte
    localparam logic [1:0] LEN_FORM_7  = 2'd0;
    localparam logic [1:0] LEN_FORM_16 = 2'd1;
    localparam logic [1:0] LEN_FORM_64 = 2'd2;

    // Receiver stall patterns
    localparam int SINK_OPEN   = 0;
    localparam int SINK_COIN   = 1;
    localparam int SINK_SPARSE = 2;
    localparam int SINK_BEAT   = 3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;   // rx_byte[7:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // payload_byte[7:0], frame_flags[15:8], frame_length[79:16]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    // was_masked[0], empty_frame[1]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    logic [7:0]  rx_stream[$];

    // Unmasked empty frame, masked empty frame, one masked byte, 16-bit length of zero
    logic [7:0] directed_seq [19] = '{
        8'h00, 8'h00,
        8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00,
        8'h8A, 8'h81, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h55,
        8'h09, 8'h7E, 8'h00, 8'h00
    };

    always #10 i_clk = ~i_clk;

    websocket_frame_deframer i_dut (.*);

    websocket_frame_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // Append one frame; payload_count may stop short of the header length
    task automatic queue_frame(input logic [7:0] flags, input logic masked,
                               input logic [1:0] form, input logic [63:0] len,
                               input int payload_count);
        logic [6:0] code;
        case (form)
            LEN_FORM_16: code = LEN_CODE_16;
            LEN_FORM_64: code = LEN_CODE_64;
            default:     code = len[6:0];
        endcase
        rx_stream.push_back(flags);
        rx_stream.push_back({masked, code});
        if (form == LEN_FORM_16) begin
            rx_stream.push_back(len[15:8]);
            rx_stream.push_back(len[7:0]);
        end else if (form == LEN_FORM_64) begin
            for (int i = 7; i >= 0; i--)
                rx_stream.push_back(len[8*i +: 8]);
        end
        if (masked)
            repeat (4) rx_stream.push_back(8'($urandom));
        repeat (payload_count) rx_stream.push_back(8'($urandom));
    endtask

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: changing stall patterns plus two long hold-offs to back up the input
    initial begin : sink
        int unsigned tick;
        int          mode;
        int          mode_left;
        tick      = 0;
        mode      = SINK_OPEN;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (mode_left == 0) begin
                mode      = $urandom_range(SINK_OPEN, SINK_BEAT);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if ((tick >= 150 && tick < 450) || (tick >= 1800 && tick < 2000))
                m_axis_tready <= 1'b0;
            else begin
                case (mode)
                    SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    SINK_BEAT:   m_axis_tready <= ((tick % 7) < 3);
                    default:     m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin : source
        int          sel;
        logic [1:0]  form;
        logic [63:0] len;
        int          burst_left;
        int          gap;

        foreach (directed_seq[i])
            rx_stream.push_back(directed_seq[i]);

        // Well-formed frames with random flags, keys and content; mostly short
        while (rx_stream.size() < STREAM_BYTES) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                form = LEN_FORM_7;
                len  = (sel < 6) ? 64'($urandom_range(100, 125)) : 64'($urandom_range(0, 10));
            end else if (sel < 80) begin
                form = LEN_FORM_16;
                len  = (sel < 64) ? 64'($urandom_range(126, 300)) : 64'($urandom_range(0, 10));
            end else begin
                form = LEN_FORM_64;
                len  = (sel < 83) ? 64'($urandom_range(256, 400)) : 64'($urandom_range(0, 10));
            end
            queue_frame(8'($urandom), 1'($urandom_range(0, 1)), form, len, int'(len));
        end

        // Last frame: 64-bit length with its top bit set, only partly sent
        len     = {$urandom, $urandom};
        len[63] = 1'b1;
        queue_frame(8'($urandom), 1'b1, LEN_FORM_64, len, MSB_PAYLOAD);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bursts of random length with random gaps
        burst_left = $urandom_range(1, 40);
        while (rx_stream.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= rx_stream.pop_front();
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= 8'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
